/* rtl/iida_pkg.sv */
`timescale 1ns / 1ps

package iida_pkg;

    localparam int CAPACITY = 256;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW       = $clog2(CAPACITY + 1);

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 9;
    localparam int DATA_W   = 32;
    localparam int FPOS_W   = 8;
    localparam int STAT_W   = 3;
    localparam int CNT_W    = 9;

    localparam int LW       = (CW > POS_W) ? CW : POS_W;

    localparam int S_TDATA_W = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + FPOS_W + STAT_W + CNT_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

endpackage

/* rtl/iida_ram.sv */
`timescale 1ns / 1ps

module iida_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/indexed_insert_delete_array_core.sv */
`timescale 1ns / 1ps

// Ordered list of signed 32-bit words held in one single-port-write, one-port-read
// RAM with a registered read. One operation is taken at a time; the input beat is
// accepted only while the core is idle, and a result held in the output register
// does not block the next beat. Push, insert at the end and unused codes go straight
// to the result; pop and read wait on one RAM read; delete, insert elsewhere and search
// walk the list, one entry per cycle, set by the single RAM read port. No clearing
// pass after reset.
module indexed_insert_delete_array_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // position, data_in
    input  logic [iida_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // func
    input  logic [iida_pkg::FUNC_W-1:0]     i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // data_out, found_position, status, count
    output logic [iida_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);

    import iida_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RDW, S_DEL, S_INS, S_INS_LAST, S_SRCH, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_prev, n_prev;
    logic [DATA_W-1:0] r_data, n_data;
    logic              r_first, n_first;
    logic [DATA_W-1:0] r_res_data, n_res_data;
    logic [FPOS_W-1:0] r_res_fpos, n_res_fpos;
    logic [STAT_W-1:0] r_res_stat, n_res_stat;
    logic              r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0] r_out_tdata, n_out_tdata;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [DATA_W-1:0] wdata, rdata;

    logic [FUNC_W-1:0] in_func;
    logic [POS_W-1:0]  in_pos;
    logic [DATA_W-1:0] in_data;
    logic              accept;
    logic              out_free;
    logic              full;
    logic [LW-1:0]     pos_l, cnt_l;
    logic [CW-1:0]     prev_next;

    assign in_func  = i_s_axis_tuser;
    assign in_pos   = i_s_axis_tdata[POS_W-1:0];
    assign in_data  = i_s_axis_tdata[POS_W+DATA_W-1:POS_W];
    assign accept   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign full     = (r_count >= CW'(CAPACITY));
    assign pos_l    = LW'(in_pos);
    assign cnt_l    = LW'(r_count);
    assign prev_next = CW'(r_prev) + CW'(1);

    iida_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_prev      = r_prev;
        n_data      = r_data;
        n_first     = r_first;
        n_res_data  = r_res_data;
        n_res_fpos  = r_res_fpos;
        n_res_stat  = r_res_stat;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_tdata = r_out_tdata;
        we          = 1'b0;
        waddr       = r_prev;
        wdata       = rdata;
        raddr       = r_prev;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_data     = in_data;
                    n_pos      = AW'(in_pos);
                    n_res_data = '0;
                    n_res_fpos = '0;
                    n_res_stat = ST_OK;
                    n_state    = S_DONE;
                    unique case (in_func) inside
                        FN_PUSH: begin
                            if (full) begin
                                n_res_stat = ST_FULL;
                            end else begin
                                we         = 1'b1;
                                waddr      = AW'(r_count);
                                wdata      = in_data;
                                n_count    = r_count + CW'(1);
                                n_res_data = in_data;
                            end
                        end
                        FN_POP: begin
                            if (r_count == '0) begin
                                n_res_stat = ST_EMPTY;
                            end else begin
                                raddr   = AW'(r_count - CW'(1));
                                n_count = r_count - CW'(1);
                                n_state = S_RDW;
                            end
                        end
                        FN_INSERT: begin
                            if (pos_l > cnt_l) begin
                                n_res_stat = ST_BADPOS;
                            end else if (full) begin
                                n_res_stat = ST_FULL;
                            end else if (pos_l == cnt_l) begin
                                we         = 1'b1;
                                waddr      = AW'(in_pos);
                                wdata      = in_data;
                                n_count    = r_count + CW'(1);
                                n_res_data = in_data;
                            end else begin
                                raddr   = AW'(r_count - CW'(1));
                                n_prev  = AW'(r_count - CW'(1));
                                n_state = S_INS;
                            end
                        end
                        FN_DELETE, FN_READ: begin
                            if (r_count == '0) begin
                                n_res_stat = ST_EMPTY;
                            end else if (pos_l >= cnt_l) begin
                                n_res_stat = ST_BADPOS;
                            end else begin
                                raddr   = AW'(in_pos);
                                n_prev  = AW'(in_pos);
                                n_first = 1'b1;
                                n_state = (in_func == FN_DELETE) ? S_DEL : S_RDW;
                            end
                        end
                        FN_SEARCH: begin
                            if (r_count == '0) begin
                                n_res_stat = ST_NOTFOUND;
                            end else begin
                                raddr   = '0;
                                n_prev  = '0;
                                n_state = S_SRCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDW: begin
                n_res_data = rdata;
                n_state    = S_DONE;
            end
            S_DEL: begin
                n_first = 1'b0;
                if (r_first) begin
                    n_res_data = rdata;
                end else begin
                    we    = 1'b1;
                    waddr = r_prev - AW'(1);
                    wdata = rdata;
                end
                if (prev_next < r_count) begin
                    raddr  = AW'(prev_next);
                    n_prev = AW'(prev_next);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_INS: begin
                we    = 1'b1;
                waddr = r_prev + AW'(1);
                wdata = rdata;
                if (r_prev > r_pos) begin
                    raddr  = r_prev - AW'(1);
                    n_prev = r_prev - AW'(1);
                end else begin
                    n_state = S_INS_LAST;
                end
            end
            S_INS_LAST: begin
                we         = 1'b1;
                waddr      = r_pos;
                wdata      = r_data;
                n_count    = r_count + CW'(1);
                n_res_data = r_data;
                n_state    = S_DONE;
            end
            S_SRCH: begin
                if (rdata == r_data) begin
                    n_res_data = r_data;
                    n_res_fpos = FPOS_W'(r_prev);
                    n_state    = S_DONE;
                end else if (prev_next < r_count) begin
                    raddr  = AW'(prev_next);
                    n_prev = AW'(prev_next);
                end else begin
                    n_res_stat = ST_NOTFOUND;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_tdata = M_TDATA_W'({CNT_W'(r_count), r_res_stat,
                                              r_res_fpos, r_res_data});
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
        r_pos       <= n_pos;
        r_prev      <= n_prev;
        r_data      <= n_data;
        r_res_data  <= n_res_data;
        r_res_fpos  <= n_res_fpos;
        r_res_stat  <= n_res_stat;
        r_out_tdata <= n_out_tdata;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (CW'(waddr) <= r_count))
        else $error("ram write beyond end of list");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("core idle right after accepting a beat");

    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && out_free |=> r_out_valid)
        else $error("finished result not loaded into output register");

endmodule

/* verif/indexed_insert_delete_array_core_tb.sv */
`timescale 1ns / 1ps

module indexed_insert_delete_array_core_tb;
    import iida_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    localparam int          NUM_ITEMS    = 1500;
    localparam int          HOLD_CYCLES  = 800;
    localparam int          DRAIN_CYCLES = CAPACITY + 64;
    localparam int          MAX_REPORTS  = 10;
    localparam longint      CYCLE_LIMIT  = 3000000;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [FPOS_W-1:0] where;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
    } t_list_result;

    typedef enum int {PH_MIXED, PH_GROW, PH_SHRINK, PH_NOISE} t_list_phase;
    typedef enum int {RX_STEADY, RX_MOSTLY, RX_HALF, RX_SPARSE} t_rx_pattern;

    class list_scoreboard;
        logic [DATA_W-1:0] entries [CAPACITY];
        int unsigned       fill = 0;
        int unsigned       peak_fill = 0;
        t_list_result      expected_q[$];
        int unsigned       mismatches = 0;
        int unsigned       checked = 0;
        int unsigned       func_seen [8];
        int unsigned       status_seen [8];

        function void note_op(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos,
                              logic [DATA_W-1:0] data);
            t_list_result r;
            int unsigned  i;
            r = '0;
            r.status = ST_OK;
            func_seen[fn]++;
            case (fn)
                FN_PUSH: begin
                    if (fill >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        entries[fill] = data;
                        fill++;
                        r.value = data;
                    end
                end
                FN_POP: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        fill--;
                        r.value = entries[fill];
                    end
                end
                FN_INSERT: begin
                    // position check wins over the full check
                    if (pos > fill) begin
                        r.status = ST_BADPOS;
                    end else if (fill >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        for (i = fill; i > pos; i--) entries[i] = entries[i - 1];
                        entries[pos] = data;
                        fill++;
                        r.value = data;
                    end
                end
                FN_DELETE: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else if (pos >= fill) begin
                        r.status = ST_BADPOS;
                    end else begin
                        r.value = entries[pos];
                        for (i = pos; i + 1 < fill; i++) entries[i] = entries[i + 1];
                        fill--;
                    end
                end
                FN_READ: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else if (pos >= fill) begin
                        r.status = ST_BADPOS;
                    end else begin
                        r.value = entries[pos];
                    end
                end
                FN_SEARCH: begin
                    r.status = ST_NOTFOUND;
                    for (i = 0; i < fill; i++) begin
                        if (entries[i] == data) begin
                            r.value  = data;
                            r.where  = FPOS_W'(i);
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
                default: begin
                end
            endcase
            r.count = CNT_W'(fill);
            if (fill > peak_fill) peak_fill = fill;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            t_list_result got;
            t_list_result want;
            got.value  = beat[DATA_W-1:0];
            got.where  = beat[DATA_W +: FPOS_W];
            got.status = beat[DATA_W+FPOS_W +: STAT_W];
            got.count  = beat[DATA_W+FPOS_W+STAT_W +: CNT_W];
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: value %0d pos %0d status %0d count %0d",
                             $signed(got.value), got.where, got.status, got.count);
                return;
            end
            want = expected_q.pop_front();
            status_seen[want.status]++;
            if (got.value !== want.value || got.where !== want.where ||
                got.status !== want.status || got.count !== want.count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"result %0d mismatch: expected value %0d pos %0d status %0d ",
                              "count %0d, got value %0d pos %0d status %0d count %0d"},
                             checked, $signed(want.value), want.where, want.status,
                             want.count, $signed(got.value), got.where, got.status,
                             got.count);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0]    s_tuser = '0;
    logic                 m_tready = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire [M_TDATA_W-1:0]  m_tdata;

    list_scoreboard sb = new;

    int unsigned  sent = 0;
    int unsigned  burst_left = 0;
    bit           gapless = 1'b0;
    int unsigned  hold_reqs = 0;
    int unsigned  hold_seen = 0;
    int unsigned  hold_left = 0;
    t_rx_pattern  rx_mode = RX_STEADY;
    int unsigned  rx_left = 0;
    longint       cycles = 0;

    indexed_insert_delete_array_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: own random pattern, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= t_rx_pattern'($urandom_range(0, 3));
                rx_left <= $urandom_range(20, 300);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_STEADY: m_tready <= 1'b1;
                RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                RX_HALF:   m_tready <= ($urandom_range(0, 1) != 0);
                default:   m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // beat monitor on both sides
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_op(s_tuser, s_tdata[POS_W-1:0], s_tdata[POS_W +: DATA_W]);
        end
    end

    task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] data);
        s_tuser  <= fn;
        s_tdata  <= {{(S_TDATA_W - POS_W - DATA_W){1'b0}}, data, pos};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        sent++;
        if (!gapless) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return DATA_W'($urandom_range(0, 15));
        if (roll < 55) return -DATA_W'($urandom_range(1, 8));
        if (roll < 85) return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int unsigned roll;
        int unsigned n;
        roll = $urandom_range(0, 99);
        n = sb.fill;
        if (roll < 10) return '0;
        if (roll < 20) return POS_W'(n);
        if (roll < 30) return POS_W'((n == 0) ? 0 : n - 1);
        if (roll < 40) return POS_W'($urandom_range(n, (1 << POS_W) - 1));
        return POS_W'($urandom_range(0, n));
    endfunction

    function automatic void make_op(input t_list_phase ph, output logic [FUNC_W-1:0] fn,
                                    output logic [POS_W-1:0] pos,
                                    output logic [DATA_W-1:0] data);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_GROW:
                fn = (roll < 35) ? FN_PUSH : (roll < 65) ? FN_INSERT :
                     (roll < 75) ? FN_READ : (roll < 85) ? FN_SEARCH :
                     (roll < 93) ? FN_DELETE : FN_POP;
            PH_SHRINK:
                fn = (roll < 30) ? FN_POP : (roll < 60) ? FN_DELETE :
                     (roll < 72) ? FN_READ : (roll < 84) ? FN_SEARCH :
                     (roll < 92) ? FN_PUSH : FN_INSERT;
            PH_NOISE:
                fn = FUNC_W'($urandom_range(0, 7));
            default:
                fn = (roll < 18) ? FN_PUSH : (roll < 32) ? FN_POP :
                     (roll < 50) ? FN_INSERT : (roll < 66) ? FN_DELETE :
                     (roll < 82) ? FN_READ : FN_SEARCH;
        endcase
        if (ph == PH_NOISE) begin
            pos  = POS_W'($urandom_range(0, (1 << POS_W) - 1));
            data = $urandom;
        end else begin
            pos = pick_position();
            if (fn == FN_SEARCH && sb.fill != 0 && $urandom_range(0, 1) == 1)
                data = sb.entries[$urandom_range(0, sb.fill - 1)];
            else
                data = pick_value();
        end
    endfunction

    initial begin
        t_list_phase       ph;
        int unsigned       phase_len;
        int unsigned       roll;
        bit                did_fill;
        bit                did_hold;
        bit                just_held;
        logic [FUNC_W-1:0] fn;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] data;

        did_fill = 1'b0;
        did_hold = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list cases, field extremes, every code
        gapless = 1'b1;
        send_op(FN_POP,      9'd0,   32'd0);
        send_op(FN_DELETE,   9'd0,   32'd0);
        send_op(FN_READ,     9'd0,   32'd0);
        send_op(FN_SEARCH,   9'd0,   32'd0);
        send_op(FN_INSERT,   9'd1,   32'd7);
        send_op(FN_INSERT,   9'd0,   32'h8000_0000);
        send_op(FN_PUSH,     9'd0,   32'h7FFF_FFFF);
        send_op(FN_PUSH,     9'd0,   32'hFFFF_FFFF);
        send_op(FN_INSERT,   9'd3,   32'd0);
        send_op(FN_INSERT,   9'd1,   32'd5);
        send_op(FN_READ,     9'd0,   32'd0);
        send_op(FN_READ,     9'd4,   32'd0);
        send_op(FN_READ,     9'd5,   32'd0);
        send_op(FN_READ,     9'd511, 32'd0);
        send_op(FN_DELETE,   9'd5,   32'd0);
        send_op(FN_DELETE,   9'd256, 32'd0);
        send_op(FN_SEARCH,   9'd0,   32'hFFFF_FFFF);
        send_op(FN_SEARCH,   9'd0,   32'h1234_5678);
        send_op(FN_SPARE_LO, 9'd511, 32'hFFFF_FFFF);
        send_op(FN_SPARE_HI, 9'd2,   32'h8000_0000);
        send_op(FN_DELETE,   9'd1,   32'd0);
        send_op(FN_POP,      9'd0,   32'd0);
        send_op(FN_INSERT,   9'd256, 32'hFFFF_FFFF);
        send_op(FN_PUSH,     9'd0,   32'h5555_AAAA);
        settle();

        while (sent < NUM_ITEMS) begin
            if (!did_fill && sent >= 700) begin
                // fill to capacity, poke the full cases, then drain
                did_fill = 1'b1;
                gapless = ($urandom_range(0, 1) == 1);
                while (sb.fill < CAPACITY) send_op(FN_PUSH, '0, pick_value());
                send_op(FN_PUSH,   '0,                 32'd1);
                send_op(FN_INSERT, '0,                 32'd2);
                send_op(FN_INSERT, POS_W'(CAPACITY),   32'd3);
                send_op(FN_INSERT, POS_W'(CAPACITY+1), 32'd4);
                send_op(FN_INSERT, '1,                 32'd5);
                send_op(FN_READ,   POS_W'(CAPACITY-1), 32'd0);
                send_op(FN_READ,   POS_W'(CAPACITY),   32'd0);
                send_op(FN_SEARCH, '0, sb.entries[CAPACITY-1]);
                send_op(FN_SEARCH, '0,                 32'h5A5A_5A5A);
                send_op(FN_DELETE, '0,                 32'd0);
                send_op(FN_INSERT, '0,                 32'h8000_0000);
                send_op(FN_DELETE, POS_W'(CAPACITY-1), 32'd0);
                send_op(FN_PUSH,   '0,                 32'h7FFF_FFFF);
                gapless = 1'b0;
                while (sb.fill > 16) begin
                    make_op(PH_SHRINK, fn, pos, data);
                    send_op(fn, pos, data);
                end
                settle();
                continue;
            end

            roll = $urandom_range(0, 3);
            if (sb.fill < 8)
                ph = (roll == 0) ? PH_NOISE : (roll == 1) ? PH_MIXED : PH_GROW;
            else if (sb.fill > 48)
                ph = (roll == 0) ? PH_MIXED : PH_SHRINK;
            else
                ph = t_list_phase'(roll);
            phase_len = $urandom_range(20, 80);
            gapless = ($urandom_range(0, 3) == 0);
            just_held = 1'b0;
            if (!did_hold && sent >= 250) begin
                // receiver holds off while items keep coming
                hold_reqs <= hold_reqs + 1;
                gapless = 1'b1;
                did_hold = 1'b1;
                just_held = 1'b1;
            end
            repeat (phase_len) begin
                make_op(ph, fn, pos, data);
                send_op(fn, pos, data);
            end
            if (just_held || $urandom_range(0, 3) == 0) settle();
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display({"sent %0d ops: push %0d pop %0d insert %0d delete %0d read %0d ",
                  "search %0d unused %0d, peak fill %0d"},
                 sent, sb.func_seen[FN_PUSH], sb.func_seen[FN_POP], sb.func_seen[FN_INSERT],
                 sb.func_seen[FN_DELETE], sb.func_seen[FN_READ], sb.func_seen[FN_SEARCH],
                 sb.func_seen[FN_SPARE_LO] + sb.func_seen[FN_SPARE_HI], sb.peak_fill);
        $display({"checked %0d results: ok %0d empty %0d bad position %0d full %0d ",
                  "not found %0d, mismatches %0d"},
                 sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
                 sb.status_seen[ST_BADPOS], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_NOTFOUND], sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
